// ===== src/cmb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RGBA color mix/blend pipeline: payload structs and the
// shared interpolation helpers. No dependencies.
package cmb_pkg;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Red/green/blue of both colors
    typedef struct packed {
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        logic [7:0] r2;
        logic [7:0] g2;
        logic [7:0] b2;
    } cmb_rgb_t;

    // Stage 1 contents: weight and alpha products
    typedef struct packed {
        logic               action;
        cmb_rgb_t           rgb;
        logic [7:0]         base_w;
        logic signed [16:0] prod_w;
        logic [7:0]         a1;
        logic signed [16:0] prod_a;
        logic [7:0]         amt;
    } cmb_s1_t;

    // Weight stage result handed to the color stages
    typedef struct packed {
        cmb_rgb_t   rgb;
        logic [7:0] w;
        logic [7:0] alpha;
    } cmb_wgt_t;

    // Stage 3 contents: color products
    typedef struct packed {
        logic [7:0]         r1;
        logic [7:0]         g1;
        logic [7:0]         b1;
        logic signed [16:0] prod_r;
        logic signed [16:0] prod_g;
        logic signed [16:0] prod_b;
        logic [7:0]         alpha;
    } cmb_s3_t;

    // Final color
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } cmb_px_t;

    // (b - a) * t, |result| <= 65025
    function automatic logic signed [16:0] lerp_prod(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] t
    );
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, t});
        return prod[16:0];
    endfunction

    // base + prod / 255, quotient truncated toward zero, clamped to 0..255
    function automatic logic [7:0] lerp_finish(
        input logic [7:0]         base,
        input logic signed [16:0] prod
    );
        logic [16:0]       neg;
        logic [15:0]       mag;
        logic [16:0]       sum;
        logic [8:0]        quo;
        logic signed [9:0] res;
        logic [7:0]        val;
        neg = 17'(-prod);
        mag = prod[16] ? neg[15:0] : prod[15:0];
        // exact divide by 255 for magnitudes up to 65025
        sum = {1'b0, mag} + 17'd1 + {9'd0, mag[15:8]};
        quo = sum[16:8];
        if (prod[16])
        begin
            res = $signed({2'b00, base}) - $signed({1'b0, quo});
        end
        else
        begin
            res = $signed({2'b00, base}) + $signed({1'b0, quo});
        end
        if (res < 0)
        begin
            val = 8'd0;
        end
        else if (res > $signed({2'b00, CHAN_MAX}))
        begin
            val = CHAN_MAX;
        end
        else
        begin
            val = res[7:0];
        end
        return val;
    endfunction

endpackage

// ===== src/cmb_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one color pair, amount and mode per transaction.
// No dependencies.
interface cmb_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] first_alpha;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] second_alpha;
    logic [7:0] mix_amount;

    modport source (
        output valid, action, first_red, first_green, first_blue, first_alpha,
        output second_red, second_green, second_blue, second_alpha, mix_amount,
        input  ready
    );
    modport sink (
        input  valid, action, first_red, first_green, first_blue, first_alpha,
        input  second_red, second_green, second_blue, second_alpha, mix_amount,
        output ready
    );
endinterface

// ===== src/cmb_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one mixed RGBA color per transaction.
// No dependencies.
interface cmb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

// ===== src/rgba_color_mix_blend.sv =====
`timescale 1ns / 1ps
// RGBA8888 mix/blend, four register stages.
// Each transaction passes through the stage 1, 2, 3 and 4 registers in order.
// Throughput: one transaction per cycle; each stage holds one item and moves
// when the stage after it is free, so bubbles close up under back-pressure.
// Reset (rst_n, async, active low) clears all stage valid bits; no other state.
module rgba_color_mix_blend (
    input  logic      clk,
    input  logic      rst_n,
    cmb_in_if.sink    pixel_in,
    cmb_out_if.source pixel_out
);

    logic              wvalid;
    logic              wready;
    cmb_pkg::cmb_wgt_t wdata;

    // weight and alpha
    cmb_wgt_stage u_wgt (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pixel_in),
        .wvalid (wvalid),
        .wready (wready),
        .wdata  (wdata)
    );

    // color channels
    cmb_rgb_stage u_rgb (
        .clk    (clk),
        .rst_n  (rst_n),
        .wvalid (wvalid),
        .wready (wready),
        .wdata  (wdata),
        .pix    (pixel_out)
    );

endmodule

// ===== src/cmb_wgt_stage.sv =====
`timescale 1ns / 1ps
// Pipeline stages 1-2: blend weight and alpha interpolation.
// Depends on cmb_pkg and cmb_in_if.
module cmb_wgt_stage (
    input  logic               clk,
    input  logic               rst_n,
    cmb_in_if.sink             pix,
    output logic               wvalid,
    input  logic               wready,
    output cmb_pkg::cmb_wgt_t  wdata
);

    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    cmb_pkg::cmb_s1_t  s1_reg, s1_next;
    cmb_pkg::cmb_wgt_t s2_reg, s2_next;
    logic              ready1, ready2;
    logic              ld1, ld2;

    // per-stage handshake
    assign ready2 = !v2_reg || wready;
    assign ready1 = !v1_reg || ready2;
    assign ld1    = pix.valid && ready1;
    assign ld2    = v1_reg && ready2;
    assign pix.ready = ready1;

    assign v1_next = ready1 ? pix.valid : v1_reg;
    assign v2_next = ready2 ? v1_reg : v2_reg;

    // stage 1: products for weight and alpha
    always_comb
    begin
        s1_next.action = pix.action;
        s1_next.rgb.r1 = pix.first_red;
        s1_next.rgb.g1 = pix.first_green;
        s1_next.rgb.b1 = pix.first_blue;
        s1_next.rgb.r2 = pix.second_red;
        s1_next.rgb.g2 = pix.second_green;
        s1_next.rgb.b2 = pix.second_blue;
        s1_next.base_w = cmb_pkg::CHAN_MAX - pix.first_alpha;
        s1_next.prod_w = cmb_pkg::lerp_prod(cmb_pkg::CHAN_MAX - pix.first_alpha,
                                            pix.second_alpha, pix.mix_amount);
        s1_next.a1     = pix.first_alpha;
        s1_next.prod_a = cmb_pkg::lerp_prod(pix.first_alpha, pix.second_alpha,
                                            pix.mix_amount);
        s1_next.amt    = pix.mix_amount;
    end

    // stage 2: divide by 255, pick weight by mode
    always_comb
    begin
        s2_next.rgb   = s1_reg.rgb;
        s2_next.w     = s1_reg.action ? cmb_pkg::lerp_finish(s1_reg.base_w, s1_reg.prod_w)
                                      : s1_reg.amt;
        s2_next.alpha = cmb_pkg::lerp_finish(s1_reg.a1, s1_reg.prod_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_reg <= s1_next;
        end
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign wvalid = v2_reg;
    assign wdata  = s2_reg;

    // a stalled stage 1 transaction stays and keeps its products
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !ready2 |=> v1_reg && $stable(s1_reg.prod_w) && $stable(s1_reg.prod_a))
        else $error("stage 1 lost or changed a stalled transaction");

    // mix mode passes the amount through as the weight
    a_mix_weight: assert property (@(posedge clk) disable iff (!rst_n)
        ld2 && !s1_reg.action |=> s2_reg.w == $past(s1_reg.amt))
        else $error("mix mode weight differs from amount");

    // stage 2 occupied and blocked stays occupied
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !wready |=> v2_reg && $stable(s2_reg))
        else $error("stage 2 lost or changed a stalled transaction");

endmodule

// ===== src/cmb_rgb_stage.sv =====
`timescale 1ns / 1ps
// Pipeline stages 3-4: red/green/blue interpolation by the blend weight.
// Depends on cmb_pkg and cmb_out_if.
module cmb_rgb_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wvalid,
    output logic               wready,
    input  cmb_pkg::cmb_wgt_t  wdata,
    cmb_out_if.source          pix
);

    logic             v3_reg, v3_next;
    logic             v4_reg, v4_next;
    cmb_pkg::cmb_s3_t s3_reg, s3_next;
    cmb_pkg::cmb_px_t s4_reg, s4_next;
    logic             ready3, ready4;
    logic             ld3, ld4;

    // per-stage handshake
    assign ready4 = !v4_reg || pix.ready;
    assign ready3 = !v3_reg || ready4;
    assign ld3    = wvalid && ready3;
    assign ld4    = v3_reg && ready4;
    assign wready = ready3;

    assign v3_next = ready3 ? wvalid : v3_reg;
    assign v4_next = ready4 ? v3_reg : v4_reg;

    // stage 3: channel products
    always_comb
    begin
        s3_next.r1     = wdata.rgb.r1;
        s3_next.g1     = wdata.rgb.g1;
        s3_next.b1     = wdata.rgb.b1;
        s3_next.prod_r = cmb_pkg::lerp_prod(wdata.rgb.r1, wdata.rgb.r2, wdata.w);
        s3_next.prod_g = cmb_pkg::lerp_prod(wdata.rgb.g1, wdata.rgb.g2, wdata.w);
        s3_next.prod_b = cmb_pkg::lerp_prod(wdata.rgb.b1, wdata.rgb.b2, wdata.w);
        s3_next.alpha  = wdata.alpha;
    end

    // stage 4: divide by 255 and add base
    always_comb
    begin
        s4_next.red   = cmb_pkg::lerp_finish(s3_reg.r1, s3_reg.prod_r);
        s4_next.green = cmb_pkg::lerp_finish(s3_reg.g1, s3_reg.prod_g);
        s4_next.blue  = cmb_pkg::lerp_finish(s3_reg.b1, s3_reg.prod_b);
        s4_next.alpha = s3_reg.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
        if (ld4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign pix.valid     = v4_reg;
    assign pix.out_red   = s4_reg.red;
    assign pix.out_green = s4_reg.green;
    assign pix.out_blue  = s4_reg.blue;
    assign pix.out_alpha = s4_reg.alpha;

    // a stalled stage 3 transaction stays and keeps its products
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !ready4 |=> v3_reg && $stable(s3_reg))
        else $error("stage 3 lost or changed a stalled transaction");

    // alpha is carried unchanged through the color stages
    a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
        ld4 |=> s4_reg.alpha == $past(s3_reg.alpha))
        else $error("alpha altered in color stages");

endmodule
